/* sv/lodd_pkg.sv */
// Shared constants and types for the lock-order deadlock detector.
// No dependencies; imported by lodd_walk and lock_order_deadlock_detector.
package lodd_pkg;

   localparam int MAX_MUTEXES = 16;
   localparam int IDX_W       = $clog2(MAX_MUTEXES);
   localparam int CNT_W       = $clog2(MAX_MUTEXES + 1);
   localparam int ID_W        = 32;
   localparam int BACKS_W     = 8;

   localparam logic [BACKS_W-1:0] BACKS_MAX = {BACKS_W{1'b1}};

   // Event kinds carried on req_tuser
   localparam logic KIND_LOCK   = 1'b0;
   localparam logic KIND_UNLOCK = 1'b1;

   typedef logic [MAX_MUTEXES-1:0] row_type;
   typedef row_type [MAX_MUTEXES-1:0] matrix_type;

   typedef struct packed {
      logic               done;
      logic [BACKS_W-1:0] back_edges;
   } walk_status_type;

endpackage

/* sv/lodd_walk.sv */
// Depth-first walk of the lock-order matrix from entry 0, one column per cycle.
// Depends on lodd_pkg; instantiated by lock_order_deadlock_detector.
module lodd_walk
   import lodd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] entry_count,
   input  matrix_type       matrix,
   output walk_status_type  status
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   depth_ff, depth_in;
   logic [IDX_W-1:0]   stack_ff [MAX_MUTEXES];
   logic [IDX_W-1:0]   stack_in [MAX_MUTEXES];
   logic [CNT_W-1:0]   cursor_ff [MAX_MUTEXES];
   logic [CNT_W-1:0]   cursor_in [MAX_MUTEXES];
   row_type            on_path_ff, on_path_in;
   row_type            closed_ff, closed_in;
   logic [BACKS_W-1:0] backs_ff, backs_in;

   logic [IDX_W-1:0]   top;
   logic [IDX_W-1:0]   vertex;
   logic [CNT_W-1:0]   column;
   logic [IDX_W-1:0]   col_idx;
   row_type            vrow;

   assign top     = IDX_W'(depth_ff - CNT_W'(1));
   assign vertex  = stack_ff[top];
   assign column  = cursor_ff[top];
   assign col_idx = column[IDX_W-1:0];
   assign vrow    = matrix[vertex];

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      depth_in   = depth_ff;
      stack_in   = stack_ff;
      cursor_in  = cursor_ff;
      on_path_in = on_path_ff;
      closed_in  = closed_ff;
      backs_in   = backs_ff;
      if (start) begin
         busy_in      = 1'b1;
         depth_in     = CNT_W'(1);
         stack_in[0]  = '0;
         cursor_in[0] = '0;
         on_path_in   = row_type'(1);
         closed_in    = '0;
         backs_in     = '0;
         if (entry_count == '0) begin
            busy_in    = 1'b0;
            done_in    = 1'b1;
            depth_in   = '0;
            on_path_in = '0;
         end
      end else if (busy_ff) begin
         if (column >= entry_count) begin
            // every column of this vertex seen: pop it
            on_path_in[vertex] = 1'b0;
            closed_in[vertex]  = 1'b1;
            depth_in           = depth_ff - CNT_W'(1);
            if (depth_ff == CNT_W'(1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            cursor_in[top] = column + CNT_W'(1);
            if (vrow[col_idx]) begin
               if (on_path_ff[col_idx]) begin
                  if (backs_ff != BACKS_MAX) begin
                     backs_in = backs_ff + BACKS_W'(1);
                  end
               end else if (!closed_ff[col_idx] && depth_ff < CNT_W'(MAX_MUTEXES)) begin
                  stack_in[depth_ff[IDX_W-1:0]]  = col_idx;
                  cursor_in[depth_ff[IDX_W-1:0]] = '0;
                  on_path_in[col_idx]            = 1'b1;
                  depth_in                       = depth_ff + CNT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         done_ff    <= 1'b0;
         depth_ff   <= '0;
         on_path_ff <= '0;
         closed_ff  <= '0;
         backs_ff   <= '0;
      end else begin
         busy_ff    <= busy_in;
         done_ff    <= done_in;
         depth_ff   <= depth_in;
         on_path_ff <= on_path_in;
         closed_ff  <= closed_in;
         backs_ff   <= backs_in;
      end
   end

   always_ff @(posedge clock) begin
      stack_ff  <= stack_in;
      cursor_ff <= cursor_in;
   end

   assign status.done       = done_ff;
   assign status.back_edges = backs_ff;

`ifndef SYNTH
   a_path_matches_depth: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $countones(on_path_ff) == int'(depth_ff))
      else $error("walk path marks disagree with stack depth");

   a_depth_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (depth_ff != '0 && depth_ff <= CNT_W'(MAX_MUTEXES)))
      else $error("walk depth out of range while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff || start))
      else $error("walk done without a walk");
`endif

endmodule

/* sv/lock_order_deadlock_detector.sv */
// Lock-order deadlock detector: mutex table, lock-order matrix and sequencer.
// A request passes through the FIND, APPLY and REPLY states; a lock also runs a walk in ST_WALK
// over the entries held after the insert, one matrix column per cycle.
// One item at a time: req_tready is high only while the sequencer is idle.
// Reset (synchronous, active high) empties the table, matrix and result.
// Depends on lodd_pkg and lodd_walk.
module lock_order_deadlock_detector
   import lodd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // mutex_id[31:0], restart[32], zero pad[39:33]
   input  logic        req_tuser,  // kind (0 lock, 1 unlock)
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // cycle_found[0], back_edges[8:1], entry_count[13:9],
                                   // overflow[14], zero pad[15]
);

   // Sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIND  = 3'd1;
   localparam logic [2:0] ST_APPLY = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_REPLY = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic               kind_ff, kind_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   prev_ff, prev_in;
   matrix_type         matrix_ff, matrix_in;
   logic [ID_W-1:0]    table_ff [MAX_MUTEXES];
   logic [ID_W-1:0]    table_in [MAX_MUTEXES];
   logic               ovf_ff, ovf_in;
   logic [BACKS_W-1:0] backs_ff, backs_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               res_found_ff, res_found_in;
   logic [BACKS_W-1:0] res_backs_ff, res_backs_in;
   logic [CNT_W-1:0]   res_count_ff, res_count_in;
   logic               res_ovf_ff, res_ovf_in;

   logic               walk_start;
   walk_status_type    walk_status;

   logic               accept;
   logic               missing;
   logic [IDX_W-1:0]   hit_idx;
   logic [CNT_W-1:0]   grown_count;
   logic [CNT_W-1:0]   shrunk_count;
   row_type            keep_mask;
   row_type            live_mask;
   matrix_type         insert_matrix;
   matrix_type         remove_matrix;
   row_type            src_row;
   logic               add_edge;

   // Mask of the n lowest entries
   function automatic row_type low_mask(input logic [CNT_W-1:0] n);
      row_type m;
      m = '0;
      for (int k = 0; k < MAX_MUTEXES; k++) begin
         m[k] = (CNT_W'(k) < n);
      end
      return m;
   endfunction

   assign accept       = req_tvalid && req_tready;
   assign req_tready   = (state_ff == ST_IDLE);
   assign missing      = (scan_ff == count_ff);
   assign hit_idx      = scan_ff[IDX_W-1:0];
   assign grown_count  = count_ff + CNT_W'(missing);
   assign shrunk_count = count_ff - CNT_W'(1);
   assign keep_mask    = low_mask(scan_ff);
   assign live_mask    = low_mask(shrunk_count);
   assign add_edge     = (prev_ff != scan_ff) && (prev_ff < grown_count);

   // Lock: clear row and column of a new entry, then add the order edge
   always_comb begin
      insert_matrix = matrix_ff;
      if (missing) begin
         for (int r = 0; r < MAX_MUTEXES; r++) begin
            insert_matrix[r][hit_idx] = 1'b0;
         end
         insert_matrix[hit_idx] = '0;
      end
      if (add_edge) begin
         insert_matrix[prev_ff[IDX_W-1:0]][hit_idx] = 1'b1;
      end
   end

   // Unlock: close the gap left by the removed row and column
   always_comb begin
      remove_matrix = '0;
      src_row       = '0;
      for (int j = 0; j < MAX_MUTEXES; j++) begin
         if (CNT_W'(j) < CNT_W'(scan_ff)) begin
            src_row = matrix_ff[j];
         end else if (j < MAX_MUTEXES - 1) begin
            src_row = matrix_ff[(j + 1) % MAX_MUTEXES];
         end else begin
            src_row = '0;
         end
         if (CNT_W'(j) < shrunk_count) begin
            remove_matrix[j] = ((src_row & keep_mask) | ((src_row >> 1) & ~keep_mask))
                               & live_mask;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      matrix_in    = matrix_ff;
      table_in     = table_ff;
      ovf_in       = ovf_ff;
      backs_in     = backs_ff;
      walk_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      res_found_in = res_found_ff;
      res_backs_in = res_backs_ff;
      res_count_in = res_count_ff;
      res_ovf_in   = res_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_tuser;
               id_in    = req_tdata[ID_W-1:0];
               scan_in  = '0;
               ovf_in   = 1'b0;
               backs_in = '0;
               state_in = ST_FIND;
               // restart applies to lock events only
               if (req_tuser == KIND_LOCK && req_tdata[ID_W]) begin
                  count_in  = '0;
                  prev_in   = '0;
                  matrix_in = '0;
               end
            end
         end
         ST_FIND: begin
            // one table entry compared per cycle; stop at a hit or at the end
            if (missing || table_ff[hit_idx] == id_ff) begin
               state_in = ST_APPLY;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         ST_APPLY: begin
            if (kind_ff == KIND_LOCK) begin
               if (missing && count_ff == CNT_W'(MAX_MUTEXES)) begin
                  ovf_in = 1'b1;
               end else begin
                  if (missing) begin
                     table_in[hit_idx] = id_ff;
                  end
                  count_in  = grown_count;
                  matrix_in = insert_matrix;
                  prev_in   = scan_ff;
               end
               walk_start = 1'b1;
               state_in   = ST_WALK;
            end else begin
               if (!missing) begin
                  for (int j = 0; j < MAX_MUTEXES - 1; j++) begin
                     if (CNT_W'(j) >= scan_ff) begin
                        table_in[j] = table_ff[j + 1];
                     end
                  end
                  count_in  = shrunk_count;
                  matrix_in = remove_matrix;
               end
               state_in = ST_REPLY;
            end
         end
         ST_WALK: begin
            if (walk_status.done) begin
               backs_in = walk_status.back_edges;
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               res_found_in = (backs_ff != '0);
               res_backs_in = backs_ff;
               res_count_in = count_ff;
               res_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         prev_ff      <= '0;
         matrix_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         matrix_ff    <= matrix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      id_ff        <= id_in;
      scan_ff      <= scan_in;
      table_ff     <= table_in;
      ovf_ff       <= ovf_in;
      backs_ff     <= backs_in;
      res_found_ff <= res_found_in;
      res_backs_ff <= res_backs_in;
      res_count_ff <= res_count_in;
      res_ovf_ff   <= res_ovf_in;
   end

   lodd_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .start       (walk_start),
      .entry_count (count_ff),
      .matrix      (matrix_ff),
      .status      (walk_status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, res_ovf_ff, res_count_ff, res_backs_ff, res_found_ff};

`ifndef SYNTH
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_MUTEXES))
      else $error("entry count above table size");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_ovf_ff) |-> res_count_ff == CNT_W'(MAX_MUTEXES))
      else $error("overflow reported with room in the table");

   a_found_matches_backs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (res_found_ff == (res_backs_ff != '0)))
      else $error("cycle flag disagrees with back-edge count");

   a_walk_to_reply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && walk_status.done) |=> state_ff == ST_REPLY)
      else $error("finished walk not followed by reply");
`endif

endmodule
